>>> hw/rtl/klex_pkg.sv
// ---------------------------------------------------------------------------
// klex_pkg
// Shared types, token codes and character helpers of the keyword token lexer.
// ---------------------------------------------------------------------------
package klex_pkg;

  localparam int POS_BITS   = 16;
  localparam int SPAN_BITS  = 16;
  localparam int KIND_BITS  = 5;
  localparam int KW_MAX_LEN = 6;
  localparam int KW_COUNT   = 8;
  localparam int WLEN_BITS  = $clog2(KW_MAX_LEN + 2);
  localparam int WIDX_BITS  = $clog2(KW_MAX_LEN);

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [KIND_BITS-1:0] kind_t;
  typedef logic [SPAN_BITS-1:0] span_t;

  localparam kind_t K_EOF      = 5'd0;
  localparam kind_t K_ILLEGAL  = 5'd1;
  localparam kind_t K_IDENT    = 5'd2;
  localparam kind_t K_INT      = 5'd3;
  localparam kind_t K_STRING   = 5'd4;
  localparam kind_t K_ASSIGN   = 5'd5;
  localparam kind_t K_PLUS     = 5'd6;
  localparam kind_t K_MINUS    = 5'd7;
  localparam kind_t K_BANG     = 5'd8;
  localparam kind_t K_SLASH    = 5'd9;
  localparam kind_t K_STAR     = 5'd10;
  localparam kind_t K_LT       = 5'd11;
  localparam kind_t K_GT       = 5'd12;
  localparam kind_t K_SEMI     = 5'd13;
  localparam kind_t K_COMMA    = 5'd14;
  localparam kind_t K_LPAREN   = 5'd15;
  localparam kind_t K_RPAREN   = 5'd16;
  localparam kind_t K_LBRACE   = 5'd17;
  localparam kind_t K_RBRACE   = 5'd18;
  localparam kind_t K_EQ       = 5'd19;
  localparam kind_t K_NOT_EQ   = 5'd20;
  localparam kind_t K_KEYWORD0 = 5'd21;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_IDENT  = 6'b000010,
    MODE_NUMBER = 6'b000100,
    MODE_STRING = 6'b001000,
    MODE_EQ     = 6'b010000,
    MODE_BANG   = 6'b100000
  } mode_t;

  typedef struct packed {
    kind_t kind;
    span_t span_start;
    span_t span_end;
  } token_t;

  // results of one byte, handed to the output buffer
  typedef struct packed {
    logic       push;
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_t;

  function automatic int kw_len(input int k);
    int len;
    case (k)
      0:       len = 2;
      1:       len = 3;
      2:       len = 4;
      3:       len = 5;
      4:       len = 4;
      5:       len = 2;
      6:       len = 4;
      default: len = 6;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input int k, input int j);
    logic [63:0] s;
    int          len;
    len = kw_len(k);
    case (k)
      0:       s = "fn";
      1:       s = "let";
      2:       s = "true";
      3:       s = "false";
      4:       s = "null";
      5:       s = "if";
      6:       s = "else";
      default: s = "return";
    endcase
    if (j < len) begin
      return s[8*(len-1-j) +: 8];
    end
    return CH_NUL;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2F:   k = K_SLASH;
      8'h2A:   k = K_STAR;
      8'h3C:   k = K_LT;
      8'h3E:   k = K_GT;
      8'h3B:   k = K_SEMI;
      8'h2C:   k = K_COMMA;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      default: k = K_ILLEGAL;
    endcase
    return k;
  endfunction

  // saturating position increment
  function automatic pos_t pos_inc(input pos_t p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  function automatic span_t to_span(input pos_t p);
    logic [63:0] w;
    w = 64'(p);
    return w[SPAN_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/klex_if.sv
// ---------------------------------------------------------------------------
// klex_if
// Valid/ready channels of the lexer: source bytes in, tokens out.
// ---------------------------------------------------------------------------
interface klex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface klex_out_if import klex_pkg::*;;
  logic  valid;
  logic  ready;
  kind_t token_kind;
  span_t span_start;
  span_t span_end;
  logic  run_last;

  modport source (output valid, output token_kind, output span_start, output span_end,
                  output run_last, input ready);
  modport sink   (input valid, input token_kind, input span_start, input span_end,
                  input run_last, output ready);
endinterface

>>> hw/rtl/klex_core.sv
// ---------------------------------------------------------------------------
// klex_core
// Input byte register, lexer state and the single-pass token step.
// ---------------------------------------------------------------------------
module klex_core import klex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  klex_in_if.sink     in_ch,
  input  logic        free,
  output step_t       step
);

  logic                 in_vld_r;
  logic [7:0]           byte_r;
  mode_t                mode_r, mode_nxt;
  pos_t                 pos_r, pos_nxt;
  pos_t                 tstart_r, tstart_nxt;
  logic [WLEN_BITS-1:0] wlen_r, wlen_nxt;
  logic [7:0]           wchars_r [KW_MAX_LEN];

  logic                 fire;
  logic                 wr_en;
  logic [WIDX_BITS-1:0] wr_idx;
  logic                 relex;
  logic                 e0, e1;
  token_t               ta, tb;
  kind_t                wkind;

  assign fire        = in_vld_r && free;
  assign in_ch.ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      wlen_r   <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      wlen_r   <= wlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      wchars_r[wr_idx] <= byte_r;
    end
  end

  // keyword compare, first table entry wins
  always_comb begin
    logic hit;
    wkind = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = (wlen_r == WLEN_BITS'(kw_len(k)));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < kw_len(k) && wchars_r[j] != kw_char(k, j)) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        wkind = K_KEYWORD0 + KIND_BITS'(k);
      end
    end
  end

  always_comb begin
    relex      = 1'b0;
    e0         = 1'b0;
    e1         = 1'b0;
    ta         = '0;
    tb         = '0;
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    wlen_nxt   = wlen_r;
    wr_en      = 1'b0;
    wr_idx     = wlen_r[WIDX_BITS-1:0];

    unique case (mode_r)
      MODE_IDENT: begin
        if (is_letter(byte_r) || is_digit(byte_r)) begin
          if (wlen_r < WLEN_BITS'(KW_MAX_LEN)) begin
            wr_en    = 1'b1;
            wlen_nxt = wlen_r + 1'b1;
          end else begin
            wlen_nxt = WLEN_BITS'(KW_MAX_LEN + 1);
          end
        end else begin
          e0    = 1'b1;
          ta    = '{kind: wkind, span_start: to_span(tstart_r), span_end: to_span(pos_r)};
          relex = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!is_digit(byte_r)) begin
          e0    = 1'b1;
          ta    = '{kind: K_INT, span_start: to_span(tstart_r), span_end: to_span(pos_r)};
          relex = 1'b1;
        end
      end
      MODE_STRING: begin
        if (byte_r == CH_QUOTE || byte_r == CH_NUL) begin
          e0 = 1'b1;
          ta = '{kind: K_STRING, span_start: to_span(tstart_r), span_end: to_span(pos_r)};
          if (byte_r == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
          end else begin
            relex = 1'b1;
          end
        end
      end
      MODE_EQ: begin
        e0 = 1'b1;
        if (byte_r == CH_EQ) begin
          ta       = '{kind: K_EQ, span_start: '0, span_end: '0};
          mode_nxt = MODE_IDLE;
        end else begin
          ta    = '{kind: K_ASSIGN, span_start: '0, span_end: '0};
          relex = 1'b1;
        end
      end
      MODE_BANG: begin
        e0 = 1'b1;
        if (byte_r == CH_EQ) begin
          ta       = '{kind: K_NOT_EQ, span_start: '0, span_end: '0};
          mode_nxt = MODE_IDLE;
        end else begin
          ta    = '{kind: K_BANG, span_start: '0, span_end: '0};
          relex = 1'b1;
        end
      end
      default: begin
        relex = 1'b1;
      end
    endcase

    // byte taken as the start of a new token
    if (relex) begin
      mode_nxt = MODE_IDLE;
      if (byte_r == CH_NUL) begin
        e1 = 1'b1;
        tb = '{kind: K_EOF, span_start: '0, span_end: '0};
      end else if (is_blank(byte_r)) begin
        mode_nxt = MODE_IDLE;
      end else if (byte_r == CH_EQ) begin
        mode_nxt = MODE_EQ;
      end else if (byte_r == CH_BANG) begin
        mode_nxt = MODE_BANG;
      end else if (byte_r == CH_QUOTE) begin
        mode_nxt   = MODE_STRING;
        tstart_nxt = pos_inc(pos_r);
      end else if (is_letter(byte_r)) begin
        mode_nxt   = MODE_IDENT;
        tstart_nxt = pos_r;
        wr_en      = 1'b1;
        wr_idx     = '0;
        wlen_nxt   = WLEN_BITS'(1);
      end else if (is_digit(byte_r)) begin
        mode_nxt   = MODE_NUMBER;
        tstart_nxt = pos_r;
      end else begin
        e1 = 1'b1;
        tb = '{kind: single_kind(byte_r), span_start: '0, span_end: '0};
      end
    end

    if (byte_r == CH_NUL) begin
      pos_nxt    = '0;
      tstart_nxt = '0;
      wlen_nxt   = '0;
      mode_nxt   = MODE_IDLE;
    end else begin
      pos_nxt = pos_inc(pos_r);
    end

    step.push  = fire;
    step.count = {1'b0, e0} + {1'b0, e1};
    step.tok0  = e0 ? ta : tb;
    step.tok1  = tb;
  end

`ifndef NO_ASSERTIONS
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !free |=> in_vld_r && $stable(byte_r))
    else $error("held byte lost or changed while output buffer full");

  a_two_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step.push && step.count == 2'd2 |-> mode_r != MODE_IDLE)
    else $error("two tokens from a byte with no pending token");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && byte_r == CH_NUL |=> pos_r == '0 && mode_r == MODE_IDLE && wlen_r == '0)
    else $error("end byte did not restart the lexer");
`endif

endmodule

>>> hw/rtl/klex_outq.sv
// ---------------------------------------------------------------------------
// klex_outq
// Two-entry result buffer; hands out the tokens of one byte in order.
// ---------------------------------------------------------------------------
module klex_outq import klex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  step_t       step,
  output logic        free,
  klex_out_if.source  out_ch
);

  logic [1:0] cnt_r;
  token_t     slot0_r, slot1_r;
  logic       pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign free = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (step.push) begin
      cnt_r <= step.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step.push) begin
      slot0_r <= step.tok0;
      slot1_r <= step.tok1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_ch.valid      = cnt_r != 2'd0;
  assign out_ch.token_kind = slot0_r.kind;
  assign out_ch.span_start = slot0_r.span_start;
  assign out_ch.span_end   = slot0_r.span_end;
  assign out_ch.run_last   = cnt_r == 2'd1;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_drop_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_ch.valid) && $past(rst_n) |-> $past(pop))
    else $error("result dropped without being taken");

  a_pair_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    step.push && step.count == 2'd2 |=> cnt_r == 2'd2 && !out_ch.run_last)
    else $error("token pair not loaded");
`endif

endmodule

>>> hw/rtl/keyword_token_lexer.sv
// ---------------------------------------------------------------------------
// keyword_token_lexer
// Streaming tokenizer: one source byte per item in, tokens out.
// ---------------------------------------------------------------------------
// in_ch carries one source byte per item; byte 0 marks end of input.
// out_ch carries tokens: kind, start and end position of literals, and
// run_last set on the last token caused by a given byte.
// A byte waits in the input register until the result buffer is free, then
// the token step writes its zero, one or two tokens into a two-entry result
// buffer, whose first entry drives out_ch.
// Throughput is one byte per cycle while each byte makes at most one token
// and out_ch takes each token as it shows; a byte with two tokens holds the
// buffer until both are taken, as the result buffer has one output port.
// An identifier or number token comes out when the byte after it arrives
// (a string token on its closing quote); '=' and '!' wait one byte to tell
// them from "==" and "!=". The end byte flushes a pending token, emits EOF
// and restarts positions at 0. Positions saturate at the top of the range.
// Reset (synchronous, rst_n low) empties both registers and returns the
// lexer to idle at position 0. When out_ch stalls, the buffer and then the
// input register fill and in_ch.ready drops; no token is lost.
// ---------------------------------------------------------------------------
module keyword_token_lexer import klex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  klex_in_if.sink     in_ch,
  klex_out_if.source  out_ch
);

  step_t step;
  logic  free;

  klex_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .free  (free),
    .step  (step)
  );

  klex_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule

>>> verif/tb_keyword_token_lexer.sv
// ---------------------------------------------------------------------------
// tb_keyword_token_lexer
// Self-checking bench for the streaming keyword token lexer. Source bytes
// (directed text, random programs and noise) are pushed through in_ch under
// random idling and one long output stall. Every accepted byte is lexed by a
// local token model; each token leaving out_ch is compared field by field with
// the oldest expected one.
// ---------------------------------------------------------------------------
module tb_keyword_token_lexer;
  import klex_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int SEND_IDLE[3] = '{30, 60, 0};
  localparam int RECV_IDLE[3] = '{60, 30, 0};

  typedef struct {
    logic [7:0] b;
    int         phase;
  } src_byte_t;

  typedef struct {
    kind_t kind;
    span_t s;
    span_t e;
    logic  last;
  } exp_token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic drv_valid = 1'b0;
  logic [7:0] drv_byte = 8'h00;
  logic drv_ready = 1'b0;

  klex_in_if  in_ch ();
  klex_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.char_byte = drv_byte;
  assign out_ch.ready    = drv_ready;

  keyword_token_lexer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  src_byte_t  src_bytes[$];
  exp_token_t exp_tokens[$];
  src_byte_t  next_src;
  exp_token_t want;

  int fill_phase = 0;
  int cur_phase = 0;
  int errors = 0;
  int bytes_sent = 0;
  int tokens_checked = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int quiet_cycles = 0;
  logic [28:0] kinds_seen = '0;

  string kw_text[8] = '{"fn", "let", "true", "false", "null", "if", "else", "return"};
  string lead_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string digit_set = "0123456789";
  string op_set = "+-/*<>;,(){}";
  string blank_set = " \t\n\r";

  // token model state
  mode_t      lex_state = MODE_IDLE;
  pos_t       next_pos = '0;
  pos_t       lit_start = '0;
  logic [7:0] word_buf[KW_MAX_LEN];
  int         word_cnt = 0;

  function automatic bit letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic pos_t sat_inc(input pos_t p);
    return (p == {POS_BITS{1'b1}}) ? p : pos_t'(p + 1);
  endfunction

  function automatic kind_t word_token();
    bit hit;
    if (word_cnt > KW_MAX_LEN) return K_IDENT;
    for (int i = 0; i < 8; i++) begin
      hit = (kw_text[i].len() == word_cnt);
      for (int j = 0; j < word_cnt && hit; j++) begin
        if (word_buf[j] != kw_text[i][j]) hit = 0;
      end
      if (hit) return kind_t'(K_KEYWORD0 + i);
    end
    return K_IDENT;
  endfunction

  function automatic kind_t op_token(input logic [7:0] c);
    case (c)
      "+": return K_PLUS;
      "-": return K_MINUS;
      "/": return K_SLASH;
      "*": return K_STAR;
      "<": return K_LT;
      ">": return K_GT;
      ";": return K_SEMI;
      ",": return K_COMMA;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      default: return K_ILLEGAL;
    endcase
  endfunction

  task automatic push_token(input kind_t k, input pos_t s, input pos_t e);
    exp_token_t t;
    t.kind = k;
    t.s    = span_t'(s);
    t.e    = span_t'(e);
    t.last = 1'b0;
    exp_tokens.push_back(t);
  endtask

  task automatic word_push(input logic [7:0] c);
    if (word_cnt < KW_MAX_LEN) begin
      word_buf[word_cnt] = c;
      word_cnt++;
    end else begin
      word_cnt = KW_MAX_LEN + 1;
    end
  endtask

  // lex one accepted byte, queue the tokens it causes
  task automatic lex_byte(input logic [7:0] c);
    int   sz0;
    bit   relex;
    pos_t p;
    sz0   = exp_tokens.size();
    relex = 0;
    p     = next_pos;
    case (lex_state)
      MODE_IDENT: begin
        if (letter_ch(c) || digit_ch(c)) begin
          word_push(c);
        end else begin
          push_token(word_token(), lit_start, p);
          relex = 1;
        end
      end
      MODE_NUMBER: begin
        if (!digit_ch(c)) begin
          push_token(K_INT, lit_start, p);
          relex = 1;
        end
      end
      MODE_STRING: begin
        if (c == "\"") begin
          push_token(K_STRING, lit_start, p);
          lex_state = MODE_IDLE;
        end else if (c == 8'h00) begin
          push_token(K_STRING, lit_start, p);
          relex = 1;
        end
      end
      MODE_EQ: begin
        if (c == "=") begin
          push_token(K_EQ, '0, '0);
          lex_state = MODE_IDLE;
        end else begin
          push_token(K_ASSIGN, '0, '0);
          relex = 1;
        end
      end
      MODE_BANG: begin
        if (c == "=") begin
          push_token(K_NOT_EQ, '0, '0);
          lex_state = MODE_IDLE;
        end else begin
          push_token(K_BANG, '0, '0);
          relex = 1;
        end
      end
      default: relex = 1;
    endcase

    if (relex) begin
      lex_state = MODE_IDLE;
      if (c == 8'h00) begin
        push_token(K_EOF, '0, '0);
      end else if (c == " " || c == "\t" || c == "\n" || c == "\r") begin
        // blanks are skipped
      end else if (c == "=") begin
        lex_state = MODE_EQ;
      end else if (c == "!") begin
        lex_state = MODE_BANG;
      end else if (c == "\"") begin
        lex_state = MODE_STRING;
        lit_start = sat_inc(p);
      end else if (letter_ch(c)) begin
        lex_state = MODE_IDENT;
        lit_start = p;
        word_cnt  = 0;
        word_push(c);
      end else if (digit_ch(c)) begin
        lex_state = MODE_NUMBER;
        lit_start = p;
      end else begin
        push_token(op_token(c), '0, '0);
      end
    end

    if (c == 8'h00) begin
      next_pos  = '0;
      lit_start = '0;
      word_cnt  = 0;
      lex_state = MODE_IDLE;
    end else begin
      next_pos = sat_inc(p);
    end

    if (exp_tokens.size() > sz0) exp_tokens[exp_tokens.size()-1].last = 1'b1;
  endtask

  // stimulus helpers
  task automatic push_b(input logic [7:0] b);
    src_byte_t it;
    it.b     = b;
    it.phase = fill_phase;
    src_bytes.push_back(it);
  endtask

  task automatic push_s(input string s);
    for (int i = 0; i < s.len(); i++) push_b(s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] word_ch();
    return ($urandom_range(0, 3) == 0) ? pick(digit_set) : pick(lead_set);
  endfunction

  task automatic add_fragment();
    int         len;
    int         k;
    int         variant;
    logic [7:0] b;
    case ($urandom_range(0, 8))
      0, 1: begin
        k       = $urandom_range(0, 7);
        len     = kw_text[k].len();
        variant = $urandom_range(0, 3);
        if (variant == 0) len--;
        for (int j = 0; j < len; j++) push_b(kw_text[k][j]);
        if (variant == 1) push_b(word_ch());
      end
      2: begin
        push_b(pick(lead_set));
        repeat ($urandom_range(0, 8)) push_b(word_ch());
      end
      3: repeat ($urandom_range(1, 5)) push_b(pick(digit_set));
      4: begin
        push_b("\"");
        repeat ($urandom_range(0, 5)) begin
          b = 8'($urandom_range(1, 255));
          if (b == "\"") b = "q";
          push_b(b);
        end
        if ($urandom_range(0, 9) != 0) push_b("\"");
      end
      5: push_b(pick(op_set));
      6: begin
        case ($urandom_range(0, 3))
          0: push_s("==");
          1: push_s("!=");
          2: push_b("=");
          default: push_b("!");
        endcase
      end
      7: repeat ($urandom_range(1, 3)) push_b(pick(blank_set));
      default: push_b(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic add_random(input int n);
    int start;
    start = src_bytes.size();
    while (src_bytes.size() - start < n) begin
      repeat ($urandom_range(2, 8)) begin
        add_fragment();
        if ($urandom_range(0, 1) != 0) push_b(pick(blank_set));
      end
      if ($urandom_range(0, 9) != 0) push_b(8'h00);
    end
    push_b(8'h00);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        lex_byte(drv_byte);
        bytes_sent++;
      end
      if (!drv_valid || in_ch.ready) begin
        if (src_bytes.size() > 0 &&
            $urandom_range(0, 99) >= SEND_IDLE[src_bytes[0].phase]) begin
          next_src  = src_bytes.pop_front();
          drv_byte  <= next_src.b;
          drv_valid <= 1'b1;
          cur_phase <= next_src.phase;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && drv_ready) begin
        if (exp_tokens.size() == 0) begin
          $error("unexpected token: kind %0d span %0d..%0d", out_ch.token_kind,
                 out_ch.span_start, out_ch.span_end);
          errors++;
        end else begin
          want = exp_tokens.pop_front();
          if (out_ch.token_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, out_ch.token_kind);
            errors++;
          end
          if (out_ch.span_start !== want.s) begin
            $error("span_start: expected %0d, got %0d", want.s, out_ch.span_start);
            errors++;
          end
          if (out_ch.span_end !== want.e) begin
            $error("span_end: expected %0d, got %0d", want.e, out_ch.span_end);
            errors++;
          end
          if (out_ch.run_last !== want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, out_ch.run_last);
            errors++;
          end
          if (want.kind <= 28) kinds_seen[want.kind] = 1'b1;
        end
        tokens_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        drv_ready <= 1'b0;
      end else if (!hold_done && tokens_checked >= 60) begin
        // long output stall so the lexer backs up into in_ch
        hold_done = 1;
        hold_left = 400;
        drv_ready <= 1'b0;
      end else begin
        drv_ready <= ($urandom_range(0, 99) >= RECV_IDLE[cur_phase]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((drv_valid && in_ch.ready) || (out_ch.valid && drv_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // directed: lone end, long name, "==", '!' then 0xff, unterminated string,
    // '=' followed by a digit, number flushed by an operator
    fill_phase = 0;
    push_b(8'h00);
    push_s("returns==!");
    push_b(8'hFF);
    push_s("\"ab");
    push_b(8'h00);
    push_s("=9;");
    push_b(8'h00);
    add_random(170);

    fill_phase = 1;
    add_random(170);

    // no idling: a few directed bytes, then random text
    fill_phase = 2;
    push_s("ab\"x");
    push_b(8'h00);
    push_s("7 ");
    push_b(8'h00);
    add_random(170);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (src_bytes.size() > 0 || drv_valid || exp_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("bytes driven: %0d, tokens checked: %0d, token kinds seen: %0d of 29",
             bytes_sent, tokens_checked, $countones(kinds_seen));
    $display("covered two idle mixes, a stall-free phase and a long output hold-off"
             , " that backs the lexer up into its input");
    if (errors == 0 && exp_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
